// ===== hdl/u16u8_pkg.sv =====
package u16u8_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned MAX_BYTES   = 6;
   localparam int unsigned COUNT_W     = $clog2(MAX_BYTES + 1);
   localparam int unsigned INDEX_W     = $clog2(MAX_BYTES);

   localparam logic [15:0] HIGH_FIRST  = 16'hD800;
   localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST   = 16'hDC00;
   localparam logic [15:0] LOW_LAST    = 16'hDFFF;
   localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] CONT_MARK  = 8'h80;
   localparam logic [7:0] LEAD_HIGH_SURROGATE = 8'hED;
   localparam logic [7:0] CONT_HIGH_SURROGATE = 8'hA0;

   // utf-8 bytes of one job, ready for serialising
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [COUNT_W-1:0]        count;
      logic                      fin;
   } job_type;

endpackage

// ===== hdl/u16u8_if.sv =====
interface u16u8_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        final_unit;

   modport source (output valid, output code_unit, output final_unit, input ready);
   modport sink (input valid, input code_unit, input final_unit, output ready);
   modport monitor (input valid, input ready, input code_unit, input final_unit);
endinterface

interface u16u8_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       stream_last;

   modport source (output valid, output out_byte, output run_last, output stream_last,
                   input ready);
   modport sink (input valid, input out_byte, input run_last, input stream_last,
                 output ready);
   modport monitor (input valid, input ready, input out_byte, input run_last,
                    input stream_last);
endinterface

// ===== hdl/u16u8_queue.sv =====
module u16u8_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             head_valid
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/u16u8_front.sv =====
module u16u8_front (
   input  logic              clock,
   input  logic              reset,
   u16u8_req_if.sink         req_if,
   input  logic              queue_full,
   output logic              push,
   output u16u8_pkg::job_type job
);

   logic       pending_ff, pending_in;
   logic [9:0] held_ff;
   logic       fire;
   logic       is_high;
   logic       is_low;
   logic       hold;
   logic [2:0][7:0] unit_bytes;
   logic [1:0] unit_len;
   logic [15:0] cu;
   logic [4:0]  plane;

   assign cu      = req_if.code_unit;
   assign fire    = req_if.valid && req_if.ready;
   assign req_if.ready = !queue_full;
   assign is_high = (cu >= u16u8_pkg::HIGH_FIRST) && (cu <= u16u8_pkg::HIGH_LAST);
   assign is_low  = (cu >= u16u8_pkg::LOW_FIRST) && (cu <= u16u8_pkg::LOW_LAST);
   assign plane   = {1'b0, held_ff[9:6]} + 5'd1;

   // utf-8 form of the current unit on its own
   always_comb begin
      unit_bytes = '0;
      if (cu < u16u8_pkg::ONE_BYTE_LIMIT) begin
         unit_bytes[0] = cu[7:0];
         unit_len      = 2'd1;
      end else if (cu < u16u8_pkg::TWO_BYTE_LIMIT) begin
         unit_bytes[0] = u16u8_pkg::LEAD_TWO | {3'b000, cu[10:6]};
         unit_bytes[1] = u16u8_pkg::CONT_MARK | {2'b00, cu[5:0]};
         unit_len      = 2'd2;
      end else begin
         unit_bytes[0] = u16u8_pkg::LEAD_THREE | {4'b0000, cu[15:12]};
         unit_bytes[1] = u16u8_pkg::CONT_MARK | {2'b00, cu[11:6]};
         unit_bytes[2] = u16u8_pkg::CONT_MARK | {2'b00, cu[5:0]};
         unit_len      = 2'd3;
      end
   end

   always_comb begin
      job        = '0;
      job.fin    = req_if.final_unit;
      hold       = 1'b0;
      pending_in = pending_ff;
      if (pending_ff && is_low) begin
         // surrogate pair, supplementary plane
         job.bytes[0] = u16u8_pkg::LEAD_FOUR | {5'b00000, plane[4:2]};
         job.bytes[1] = u16u8_pkg::CONT_MARK | {2'b00, plane[1:0], held_ff[5:2]};
         job.bytes[2] = u16u8_pkg::CONT_MARK | {2'b00, held_ff[1:0], cu[9:6]};
         job.bytes[3] = u16u8_pkg::CONT_MARK | {2'b00, cu[5:0]};
         job.count    = u16u8_pkg::COUNT_W'(4);
         pending_in   = 1'b0;
      end else begin
         if (pending_ff) begin
            // lone high surrogate flushed as three bytes
            job.bytes[0] = u16u8_pkg::LEAD_HIGH_SURROGATE;
            job.bytes[1] = u16u8_pkg::CONT_HIGH_SURROGATE | {4'b0000, held_ff[9:6]};
            job.bytes[2] = u16u8_pkg::CONT_MARK | {2'b00, held_ff[5:0]};
            job.count    = u16u8_pkg::COUNT_W'(3);
         end
         if (is_high && !req_if.final_unit) begin
            hold       = 1'b1;
            pending_in = 1'b1;
         end else begin
            pending_in = 1'b0;
            if (pending_ff) begin
               job.bytes[5:3] = unit_bytes;
            end else begin
               job.bytes[2:0] = unit_bytes;
            end
            job.count = job.count + u16u8_pkg::COUNT_W'(unit_len);
         end
      end
   end

   assign push = fire && (job.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else if (fire) begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && hold) begin
         held_ff <= cu[9:0];
      end
   end

endmodule

// ===== hdl/u16u8_back.sv =====
module u16u8_back (
   input  logic              clock,
   input  logic              reset,
   input  u16u8_pkg::job_type head,
   input  logic              head_valid,
   output logic              pop,
   u16u8_rsp_if.source       rsp_if
);

   logic                          valid_ff;
   logic [7:0]                    byte_ff;
   logic                          run_last_ff;
   logic                          stream_last_ff;
   logic [u16u8_pkg::INDEX_W-1:0] index_ff, index_in;
   logic                          load;
   logic                          at_last;

   assign load    = head_valid && (!valid_ff || rsp_if.ready);
   assign at_last = (u16u8_pkg::COUNT_W'(index_ff) == head.count - 1'b1);
   assign pop     = load && at_last;
   assign index_in = at_last ? '0 : index_ff + 1'b1;

   assign rsp_if.valid       = valid_ff;
   assign rsp_if.out_byte    = byte_ff;
   assign rsp_if.run_last    = run_last_ff;
   assign rsp_if.stream_last = stream_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            index_ff <= index_in;
         end else if (rsp_if.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff        <= head.bytes[index_ff];
         run_last_ff    <= at_last;
         stream_last_ff <= at_last && head.fin;
      end
   end

endmodule

// ===== hdl/utf16_to_utf8_transcoder_core.sv =====
// channel  direction  payload                              accepted when
// req_if   in         code_unit[15:0], final_unit          valid && ready
// rsp_if   out        out_byte[7:0], run_last, stream_last valid && ready
//
// one utf-8 byte leaves per cycle while rsp_if is ready and a job is queued; a job
// yields 1 to 3 bytes, 4 for a surrogate pair, up to 6 with a flush
// the front takes one code unit per cycle while the job queue has room
// reset is synchronous and empties the queue, the output register and any held surrogate
// rsp_if stalls hold the output register; the queue absorbs short bursts
module utf16_to_utf8_transcoder_core #(
   parameter int unsigned QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   u16u8_req_if.sink    req_if,
   u16u8_rsp_if.source  rsp_if
);

   u16u8_pkg::job_type front_job;
   u16u8_pkg::job_type head_job;
   logic               push;
   logic               queue_full;
   logic               pop;
   logic               head_valid;

   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push),
      .job        (front_job)
   );

   u16u8_queue #(
      .WIDTH ($bits(u16u8_pkg::job_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (front_job),
      .full       (queue_full),
      .pop        (pop),
      .head       (head_job),
      .head_valid (head_valid)
   );

   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_job),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

// ===== hdl/u16u8_checker.sv =====
module u16u8_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last,
   input logic       rsp_stream_last
);

   // stalled transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_run_last) && $stable(rsp_stream_last))
      else $error("stalled rsp transaction changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_last |-> rsp_run_last)
      else $error("stream_last without run_last");

   // a multi-byte lead byte is always followed by continuation bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_byte[7:6] == 2'b11) |-> !rsp_run_last)
      else $error("run ends on a lead byte");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_out_byte[7:6] == 2'b11)
         |=> !rsp_valid || (rsp_out_byte[7:6] == 2'b10))
      else $error("lead byte not followed by continuation byte");

endmodule

bind utf16_to_utf8_transcoder_core u16u8_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_out_byte    (rsp_if.out_byte),
   .rsp_run_last    (rsp_if.run_last),
   .rsp_stream_last (rsp_if.stream_last)
);
